// File: rtl/dfq_pkg.sv
// ----------------------------------------------------------------------------
// dfq_pkg
// shared types, sizes and helpers for the deduplicating fifo queue
// ----------------------------------------------------------------------------
package dfq_pkg;

  localparam int CAPACITY    = 16;
  localparam int KEY_BITS    = 32;
  localparam int IDX_W       = (CAPACITY > 1) ? $clog2(CAPACITY) : 1;
  localparam int CNT_W       = $clog2(CAPACITY + 1);
  localparam int KEY_PORT_W  = 32;
  localparam int COUNT_PORT_W = 5;

  typedef logic [KEY_BITS-1:0]     key_t;
  typedef logic [IDX_W-1:0]        idx_t;
  typedef logic [CNT_W-1:0]        cnt_t;
  typedef logic [KEY_PORT_W-1:0]   key_port_t;
  typedef logic [COUNT_PORT_W-1:0] count_port_t;

  localparam logic OP_ENQ = 1'b0;
  localparam logic OP_DEQ = 1'b1;

  typedef enum logic [1:0] {
    ST_DONE  = 2'd0,
    ST_DUP   = 2'd1,
    ST_FULL  = 2'd2,
    ST_EMPTY = 2'd3
  } status_t;

  function automatic idx_t next_slot(idx_t s);
    idx_t r;
    if (s == idx_t'(CAPACITY - 1)) begin
      r = '0;
    end else begin
      r = idx_t'(s + idx_t'(1));
    end
    return r;
  endfunction

  function automatic key_t port_to_key(key_port_t k);
    logic [127:0] w;
    w = 128'(k);
    return w[KEY_BITS-1:0];
  endfunction

  function automatic key_port_t key_to_port(key_t k);
    logic [127:0] w;
    w = 128'(k);
    return w[KEY_PORT_W-1:0];
  endfunction

  function automatic count_port_t cnt_to_port(cnt_t c);
    logic [127:0] w;
    w = 128'(c);
    return w[COUNT_PORT_W-1:0];
  endfunction

endpackage

// File: rtl/dedup_fifo_queue.sv
// ----------------------------------------------------------------------------
// dedup_fifo_queue
// fifo queue of keys that drops an enqueue whose key is already queued
// ----------------------------------------------------------------------------
//  channel   ports                                        handshake
//  input     in_opcode, in_key_in                         start && !busy
//  result    out_status, out_key_out, out_count_out       out_valid, one cycle
//
//  an enqueue into an empty queue is written straight from idle; otherwise
//  the head-to-tail duplicate scan reads one entry a cycle through the
//  single ram read port. a dequeue reads the head in S_DEQ unless empty. the
//  result is registered in the cycle after the last work cycle; busy falls at
//  the same edge, so the next item may be started while the result is shown.
//  synchronous reset empties the queue; the key ram needs no clearing.
module dedup_fifo_queue (
  input  logic                  clk,
  input  logic                  rst_n,
  input  logic                  start,
  output logic                  busy,
  input  logic                  in_opcode,
  input  dfq_pkg::key_port_t    in_key_in,
  output logic                  out_valid,
  output logic [1:0]            out_status,
  output dfq_pkg::key_port_t    out_key_out,
  output dfq_pkg::count_port_t  out_count_out
);

  import dfq_pkg::*;

  typedef enum logic [2:0] {
    S_IDLE = 3'b001,
    S_SCAN = 3'b010,
    S_DEQ  = 3'b100
  } state_t;

  state_t      state_r, state_nxt;
  idx_t        head_r, head_nxt;
  idx_t        tail_r, tail_nxt;
  cnt_t        count_r, count_nxt;
  idx_t        scan_r, scan_nxt;
  cnt_t        left_r, left_nxt;
  key_t        key_r, key_nxt;

  logic        out_valid_r, out_valid_nxt;
  status_t     out_status_r, out_status_nxt;
  key_t        out_key_r, out_key_nxt;
  cnt_t        out_count_r, out_count_nxt;

  logic        ram_we;
  idx_t        ram_waddr;
  key_t        ram_wdata;
  idx_t        ram_raddr;
  key_t        ram_rdata;

  logic        accept;
  key_t        key_in;

  assign accept = start && (state_r == S_IDLE);
  assign key_in = port_to_key(in_key_in);

  dfq_ram #(
    .WIDTH (KEY_BITS),
    .DEPTH (CAPACITY)
  ) u_key_ram (
    .clk   (clk),
    .we    (ram_we),
    .waddr (ram_waddr),
    .wdata (ram_wdata),
    .raddr (ram_raddr),
    .rdata (ram_rdata)
  );

  always_comb begin
    state_nxt      = state_r;
    head_nxt       = head_r;
    tail_nxt       = tail_r;
    count_nxt      = count_r;
    scan_nxt       = scan_r;
    left_nxt       = left_r;
    key_nxt        = key_r;
    out_valid_nxt  = 1'b0;
    out_status_nxt = out_status_r;
    out_key_nxt    = out_key_r;
    out_count_nxt  = out_count_r;
    ram_we         = 1'b0;
    ram_waddr      = tail_r;
    ram_wdata      = key_r;
    ram_raddr      = head_r;

    case (state_r)
      S_IDLE: begin
        if (accept) begin
          key_nxt = key_in;
          if (in_opcode == OP_DEQ) begin
            if (count_r == '0) begin
              out_valid_nxt  = 1'b1;
              out_status_nxt = ST_EMPTY;
              out_key_nxt    = '0;
              out_count_nxt  = count_r;
            end else begin
              ram_raddr = head_r;
              state_nxt = S_DEQ;
            end
          end else begin
            if (count_r == '0) begin
              ram_we         = 1'b1;
              ram_waddr      = tail_r;
              ram_wdata      = key_in;
              tail_nxt       = next_slot(tail_r);
              count_nxt      = cnt_t'(count_r + cnt_t'(1));
              out_valid_nxt  = 1'b1;
              out_status_nxt = ST_DONE;
              out_key_nxt    = '0;
              out_count_nxt  = cnt_t'(count_r + cnt_t'(1));
            end else begin
              ram_raddr = head_r;
              scan_nxt  = next_slot(head_r);
              left_nxt  = cnt_t'(count_r - cnt_t'(1));
              state_nxt = S_SCAN;
            end
          end
        end
      end

      S_SCAN: begin
        if (ram_rdata == key_r) begin
          out_valid_nxt  = 1'b1;
          out_status_nxt = ST_DUP;
          out_key_nxt    = '0;
          out_count_nxt  = count_r;
          state_nxt      = S_IDLE;
        end else if (left_r == '0) begin
          out_valid_nxt = 1'b1;
          out_key_nxt   = '0;
          state_nxt     = S_IDLE;
          if (count_r == cnt_t'(CAPACITY)) begin
            out_status_nxt = ST_FULL;
            out_count_nxt  = count_r;
          end else begin
            ram_we         = 1'b1;
            ram_waddr      = tail_r;
            ram_wdata      = key_r;
            tail_nxt       = next_slot(tail_r);
            count_nxt      = cnt_t'(count_r + cnt_t'(1));
            out_status_nxt = ST_DONE;
            out_count_nxt  = cnt_t'(count_r + cnt_t'(1));
          end
        end else begin
          ram_raddr = scan_r;
          scan_nxt  = next_slot(scan_r);
          left_nxt  = cnt_t'(left_r - cnt_t'(1));
        end
      end

      S_DEQ: begin
        head_nxt       = next_slot(head_r);
        count_nxt      = cnt_t'(count_r - cnt_t'(1));
        out_valid_nxt  = 1'b1;
        out_status_nxt = ST_DONE;
        out_key_nxt    = ram_rdata;
        out_count_nxt  = cnt_t'(count_r - cnt_t'(1));
        state_nxt      = S_IDLE;
      end

      default: begin
        state_nxt = S_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= S_IDLE;
      head_r      <= '0;
      tail_r      <= '0;
      count_r     <= '0;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      head_r      <= head_nxt;
      tail_r      <= tail_nxt;
      count_r     <= count_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    scan_r       <= scan_nxt;
    left_r       <= left_nxt;
    key_r        <= key_nxt;
    out_status_r <= out_status_nxt;
    out_key_r    <= out_key_nxt;
    out_count_r  <= out_count_nxt;
  end

  assign busy          = (state_r != S_IDLE);
  assign out_valid     = out_valid_r;
  assign out_status    = out_status_r;
  assign out_key_out   = key_to_port(out_key_r);
  assign out_count_out = cnt_to_port(out_count_r);

endmodule

// File: rtl/dfq_ram.sv
// ----------------------------------------------------------------------------
// dfq_ram
// generic simple dual port ram, one write and one registered read per cycle
// ----------------------------------------------------------------------------
module dfq_ram #(
  parameter int WIDTH = 32,
  parameter int DEPTH = 16
) (
  input  logic                             clk,
  input  logic                             we,
  input  logic [$clog2(DEPTH)-1:0]         waddr,
  input  logic [WIDTH-1:0]                 wdata,
  input  logic [$clog2(DEPTH)-1:0]         raddr,
  output logic [WIDTH-1:0]                 rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata <= mem[raddr];
  end

endmodule
